[hdl/jts_pkg.sv]
// ----------------------------------------------------------------------------
// jts_pkg
// Shared types and constants of the JSON token scanner: result record,
// result and token kind codes, lexer modes and character codes.
// ----------------------------------------------------------------------------
package jts_pkg;

	localparam logic [1:0] RK_NEW = 2'd0;
	localparam logic [1:0] RK_LEN = 2'd1;
	localparam logic [1:0] RK_INC = 2'd2;
	localparam logic [1:0] RK_ERR = 2'd3;

	localparam logic [2:0] TK_OBJECT = 3'd0;
	localparam logic [2:0] TK_ARRAY  = 3'd1;
	localparam logic [2:0] TK_STRING = 3'd2;
	localparam logic [2:0] TK_BOOL   = 3'd3;
	localparam logic [2:0] TK_NULL   = 3'd4;
	localparam logic [2:0] TK_NUMBER = 3'd5;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_STR  = 2'd1;
	localparam logic [1:0] MODE_ESC  = 2'd2;
	localparam logic [1:0] MODE_PRIM = 2'd3;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] PRINT_LO  = 8'd32;
	localparam logic [7:0] PRINT_HI  = 8'd127;

	// Result queue geometry; a byte can produce up to three results.
	localparam int RQ_DEPTH = 8;
	localparam int RQ_AW    = 3;
	localparam int RQ_CW    = 4;
	localparam int MAX_RUN  = 3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] index;
		logic [2:0]  tkind;
		logic [23:0] start;
		logic [24:0] length;
		logic        last;
	} result_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic clr;
	} stk_op_t;

	function automatic result_t mk_result(input logic [1:0] kind, input logic [15:0] index,
			input logic [2:0] tkind, input logic [23:0] start, input logic [24:0] length);
		result_t r;
		r.kind   = kind;
		r.index  = index;
		r.tkind  = tkind;
		r.start  = start;
		r.length = length;
		r.last   = 1'b0;
		return r;
	endfunction

endpackage

[hdl/jts_scope_stack.sv]
// ----------------------------------------------------------------------------
// jts_scope_stack
// Stack of open containers. The two topmost entries live in registers and a
// third is prefetched from the memory, so pushes and pops can run back to back.
// ----------------------------------------------------------------------------
module jts_scope_stack #(
	parameter int SCOPE_DEPTH = 32,
	parameter int TOK_W       = 17,
	parameter int OFFSET_BITS = 24,
	parameter int DW          = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  jts_pkg::stk_op_t       op,
	input  logic                   push_kind,
	input  logic [TOK_W-1:0]       push_tok,
	input  logic [OFFSET_BITS-1:0] push_start,
	output logic [DW-1:0]          depth,
	output logic                   top_kind,
	output logic [TOK_W-1:0]       top_tok,
	output logic [OFFSET_BITS-1:0] top_start,
	output logic [TOK_W-1:0]       sec_tok
);
	import jts_pkg::*;

	localparam int EW = 1 + TOK_W + OFFSET_BITS;
	localparam int AW = $clog2(SCOPE_DEPTH);

	logic [EW-1:0] mem [SCOPE_DEPTH];
	logic [EW-1:0] top_q, sec_q, third_q, new_entry;
	logic [DW-1:0] depth_q, depth_n;

	assign new_entry = {push_kind, push_tok, push_start};

	always_comb begin
		depth_n = depth_q;
		if (op.clr)
			depth_n = '0;
		else if (op.push)
			depth_n = depth_q + DW'(1);
		else if (op.pop)
			depth_n = depth_q - DW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			depth_q <= '0;
		else
			depth_q <= depth_n;
	end

	// The entry below the second is read ahead for the next pop.
	always_ff @(posedge clk) begin
		if (op.push && !op.clr)
			mem[AW'(depth_q)] <= new_entry;
		third_q <= mem[AW'(depth_n - DW'(3))];
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			top_q <= new_entry;
			sec_q <= top_q;
		end else if (op.pop) begin
			top_q <= sec_q;
			sec_q <= third_q;
		end
	end

	assign depth     = depth_q;
	assign top_kind  = top_q[EW-1];
	assign top_tok   = top_q[EW-2 -: TOK_W];
	assign top_start = top_q[OFFSET_BITS-1:0];
	assign sec_tok   = sec_q[EW-2 -: TOK_W];

endmodule

[hdl/jts_lexer.sv]
// ----------------------------------------------------------------------------
// jts_lexer
// Scanner state and the per-byte decision logic. Each fired byte yields up
// to three result records in the same cycle.
// ----------------------------------------------------------------------------
module jts_lexer #(
	parameter int SCOPE_DEPTH = 32,
	parameter int MAX_TOKENS  = 65536,
	parameter int OFFSET_BITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      fire,
	input  logic [7:0]                b,
	input  logic                      eod,
	output jts_pkg::result_t [2:0]    res,
	output logic [1:0]                res_cnt
);
	import jts_pkg::*;

	localparam int TOK_W = $clog2(MAX_TOKENS + 1);
	localparam int OW    = OFFSET_BITS + 1;
	localparam int DW    = $clog2(SCOPE_DEPTH + 1);
	localparam logic [TOK_W-1:0] TOK_MAX = TOK_W'(MAX_TOKENS);
	localparam logic [DW-1:0]    DEPTH_MAX = DW'(SCOPE_DEPTH);

	logic [TOK_W-1:0] ptok_q, ptok_n, tok_q, tok_n;
	logic             pp_q, pp_n, pc_q, pc_n, err_q, err_n;
	logic [OW-1:0]    off_q, off_n, open_q, open_n, pos;
	logic [1:0]       mode_q, mode_n;
	logic [2:0]       pkind_q, pkind_n, lkind_q, lkind_n, k;
	logic [1:0]       n;
	logic             do_between, clr, is_delim, printable;
	stk_op_t          op;
	logic [DW-1:0]    depth;
	logic             top_kind;
	logic [TOK_W-1:0] top_tok, sec_tok;
	logic [OFFSET_BITS-1:0] top_start;

	jts_scope_stack #(
		.SCOPE_DEPTH(SCOPE_DEPTH),
		.TOK_W(TOK_W),
		.OFFSET_BITS(OFFSET_BITS),
		.DW(DW)
	) u_stack (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.push_kind(k[0]),
		.push_tok(tok_q),
		.push_start(pos[OFFSET_BITS-1:0]),
		.depth(depth),
		.top_kind(top_kind),
		.top_tok(top_tok),
		.top_start(top_start),
		.sec_tok(sec_tok)
	);

	always_comb begin
		is_delim = (b == CH_TAB) || (b == CH_CR) || (b == CH_LF) || (b == CH_SPACE) ||
			(b == CH_COMMA) || (b == CH_RBRACK) || (b == CH_RBRACE);
		printable = (b >= PRINT_LO) && (b < PRINT_HI);
		k = (b == CH_LBRACE || b == CH_RBRACE) ? TK_OBJECT : TK_ARRAY;
	end

	always_comb begin
		ptok_n = ptok_q; pp_n = pp_q; pc_n = pc_q; tok_n = tok_q; err_n = err_q;
		off_n = off_q; open_n = open_q; mode_n = mode_q; pkind_n = pkind_q;
		lkind_n = lkind_q;
		pos = off_q;
		n = '0;
		res = '0;
		op = '0;
		clr = 1'b0;
		do_between = 1'b0;
		if (fire) begin
			if (err_q) begin
				clr = eod;
			end else begin
				if (off_q[OFFSET_BITS]) begin
					res[n] = mk_result(RK_ERR, '0, '0, 24'(pos), '0);
					n = n + 2'd1;
					err_n = 1'b1;
				end else begin
					case (mode_q)
						MODE_STR: begin
							if (b == CH_QUOTE) begin
								mode_n = MODE_IDLE;
								if (tok_q >= TOK_MAX) begin
									res[n] = mk_result(RK_ERR, '0, '0, 24'(pos), '0);
									n = n + 2'd1;
									err_n = 1'b1;
								end else begin
									res[n] = mk_result(RK_NEW, 16'(tok_q), TK_STRING,
										24'(open_q), 25'(pos - open_q));
									n = n + 2'd1;
									tok_n = tok_q + TOK_W'(1);
									lkind_n = TK_STRING;
									if (pp_q) begin
										res[n] = mk_result(RK_INC, 16'(ptok_q), '0, '0, '0);
										n = n + 2'd1;
									end
								end
							end else if (b == CH_BSLASH) begin
								mode_n = MODE_ESC;
							end
						end
						MODE_ESC: begin
							if (b inside {CH_QUOTE, CH_SLASH, CH_BSLASH, CH_B, CH_F, CH_R,
									CH_N, CH_T, CH_U}) begin
								mode_n = MODE_STR;
							end else begin
								res[n] = mk_result(RK_ERR, '0, '0, 24'(pos), '0);
								n = n + 2'd1;
								err_n = 1'b1;
							end
						end
						MODE_PRIM: begin
							if (is_delim) begin
								mode_n = MODE_IDLE;
								if (tok_q >= TOK_MAX) begin
									res[n] = mk_result(RK_ERR, '0, '0, 24'(pos), '0);
									n = n + 2'd1;
									err_n = 1'b1;
								end else begin
									res[n] = mk_result(RK_NEW, 16'(tok_q), pkind_q,
										24'(open_q), 25'(pos - open_q));
									n = n + 2'd1;
									tok_n = tok_q + TOK_W'(1);
									lkind_n = pkind_q;
									if (pp_q) begin
										res[n] = mk_result(RK_INC, 16'(ptok_q), '0, '0, '0);
										n = n + 2'd1;
									end
									do_between = 1'b1;
								end
							end else if (!printable) begin
								res[n] = mk_result(RK_ERR, '0, '0, 24'(pos), '0);
								n = n + 2'd1;
								err_n = 1'b1;
							end
						end
						default: do_between = 1'b1;
					endcase

					if (do_between) begin
						if (b == CH_LBRACE || b == CH_LBRACK) begin
							if (tok_n >= TOK_MAX || depth >= DEPTH_MAX) begin
								res[n] = mk_result(RK_ERR, '0, '0, 24'(pos), '0);
								n = n + 2'd1;
								err_n = 1'b1;
							end else begin
								if (pp_n) begin
									res[n] = mk_result(RK_INC, 16'(ptok_n), '0, '0, '0);
									n = n + 2'd1;
								end
								res[n] = mk_result(RK_NEW, 16'(tok_n), k, 24'(pos), '0);
								n = n + 2'd1;
								op.push = 1'b1;
								ptok_n = tok_n;
								pp_n = 1'b1;
								pc_n = 1'b1;
								lkind_n = k;
								tok_n = tok_n + TOK_W'(1);
							end
						end else if (b == CH_RBRACE || b == CH_RBRACK) begin
							if (depth == '0 || top_kind != k[0]) begin
								res[n] = mk_result(RK_ERR, '0, '0, 24'(pos), '0);
								n = n + 2'd1;
								err_n = 1'b1;
							end else begin
								res[n] = mk_result(RK_LEN, 16'(top_tok), k, 24'(top_start),
									25'(pos + OW'(1) - OW'(top_start)));
								n = n + 2'd1;
								op.pop = 1'b1;
								if (depth > DW'(1)) begin
									ptok_n = sec_tok;
									pp_n = 1'b1;
									pc_n = 1'b1;
								end else begin
									ptok_n = '0;
									pp_n = 1'b0;
									pc_n = 1'b0;
								end
							end
						end else if (b == CH_TAB || b == CH_CR || b == CH_LF ||
								b == CH_SPACE) begin
							// Whitespace between tokens has no effect.
						end else if (b == CH_COLON) begin
							if (tok_n != '0) begin
								ptok_n = tok_n - TOK_W'(1);
								pp_n = 1'b1;
								pc_n = (lkind_n <= TK_ARRAY);
							end else begin
								ptok_n = '0;
								pp_n = 1'b0;
								pc_n = 1'b0;
							end
						end else if (b == CH_COMMA) begin
							// A comma after a key's value returns to the enclosing container.
							if (pp_n && !pc_n && depth != '0) begin
								ptok_n = top_tok;
								pc_n = 1'b1;
							end
						end else if (b == CH_QUOTE) begin
							mode_n = MODE_STR;
							open_n = pos + OW'(1);
						end else if (!printable) begin
							res[n] = mk_result(RK_ERR, '0, '0, 24'(pos), '0);
							n = n + 2'd1;
							err_n = 1'b1;
						end else begin
							mode_n = MODE_PRIM;
							open_n = pos;
							if (b == CH_T || b == CH_F)
								pkind_n = TK_BOOL;
							else if (b == CH_N)
								pkind_n = TK_NULL;
							else
								pkind_n = TK_NUMBER;
						end
					end
					off_n = pos + OW'(1);
				end

				// A primitive still open at the last byte ends there.
				if (eod && !err_n && mode_n == MODE_PRIM) begin
					mode_n = MODE_IDLE;
					if (tok_n >= TOK_MAX) begin
						res[n] = mk_result(RK_ERR, '0, '0, 24'(pos), '0);
						n = n + 2'd1;
						err_n = 1'b1;
					end else begin
						res[n] = mk_result(RK_NEW, 16'(tok_n), pkind_n, 24'(open_n),
							25'(pos + OW'(1) - open_n));
						n = n + 2'd1;
						if (pp_n) begin
							res[n] = mk_result(RK_INC, 16'(ptok_n), '0, '0, '0);
							n = n + 2'd1;
						end
					end
				end
				clr = eod;
			end
			if (n != '0)
				res[n - 2'd1].last = 1'b1;
		end
		op.clr = clr;
		if (clr) begin
			ptok_n = '0; pp_n = 1'b0; pc_n = 1'b0; tok_n = '0; err_n = 1'b0;
			off_n = '0; open_n = '0; mode_n = MODE_IDLE; pkind_n = '0; lkind_n = '0;
		end
		res_cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptok_q <= '0; pp_q <= 1'b0; pc_q <= 1'b0; tok_q <= '0; err_q <= 1'b0;
			off_q <= '0; open_q <= '0; mode_q <= MODE_IDLE; pkind_q <= '0;
			lkind_q <= '0;
		end else begin
			ptok_q <= ptok_n; pp_q <= pp_n; pc_q <= pc_n; tok_q <= tok_n; err_q <= err_n;
			off_q <= off_n; open_q <= open_n; mode_q <= mode_n; pkind_q <= pkind_n;
			lkind_q <= lkind_n;
		end
	end

endmodule

[hdl/jts_result_fifo.sv]
// ----------------------------------------------------------------------------
// jts_result_fifo
// Small result queue that takes up to three records per cycle and hands out
// one per cycle while rd_stall is low.
// ----------------------------------------------------------------------------
module jts_result_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  jts_pkg::result_t [2:0] wr_data,
	input  logic [1:0]             wr_cnt,
	output logic                   room,
	output logic                   rd_valid,
	input  logic                   rd_stall,
	output jts_pkg::result_t       rd_data
);
	import jts_pkg::*;

	result_t          q [RQ_DEPTH];
	logic [RQ_AW-1:0] wp_q, rp_q;
	logic [RQ_CW-1:0] cnt_q;
	logic             pop;

	assign rd_valid = (cnt_q != '0);
	assign pop      = rd_valid && !rd_stall;
	assign rd_data  = q[rp_q];
	assign room     = (cnt_q <= RQ_CW'(RQ_DEPTH - MAX_RUN));

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RUN; i++) begin
			if (RQ_CW'(i) < RQ_CW'(wr_cnt))
				q[wp_q + RQ_AW'(i)] <= wr_data[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + RQ_AW'(wr_cnt);
			rp_q  <= rp_q + RQ_AW'(pop);
			cnt_q <= cnt_q + RQ_CW'(wr_cnt) - RQ_CW'(pop);
		end
	end

endmodule

[hdl/json_token_scanner.sv]
// An accepted byte is registered, scanned, and its results queued for the output.
// Throughput: one byte per cycle; the output carries one result per cycle while
// result_stall is low, and an eight-entry result queue holds input back only when
// it lacks room for three.
// Reset (arst_n low) clears all scanner state; the end_of_document byte also
// returns the scanner to its reset state.
// ----------------------------------------------------------------------------
// json_token_scanner
// Streaming JSON tokenizer: one text byte in, token records out.
// ----------------------------------------------------------------------------
module json_token_scanner #(
	parameter int SCOPE_DEPTH = 32,
	parameter int MAX_TOKENS  = 65536,
	parameter int OFFSET_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_document,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  result_kind,
	output logic [15:0] token_index,
	output logic [2:0]  token_kind,
	output logic [23:0] start_offset,
	output logic [24:0] token_length,
	output logic        last_of_run
);
	import jts_pkg::*;

	logic             valid_s1, eod_s1, room, fire;
	logic [7:0]       byte_s1;
	result_t [2:0]    res;
	logic [1:0]       res_cnt;
	result_t          head;

	assign fire       = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!byte_stall)
			valid_s1 <= byte_valid;
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
			eod_s1  <= end_of_document;
		end
	end

	jts_lexer #(
		.SCOPE_DEPTH(SCOPE_DEPTH),
		.MAX_TOKENS(MAX_TOKENS),
		.OFFSET_BITS(OFFSET_BITS)
	) u_lexer (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.b(byte_s1),
		.eod(eod_s1),
		.res(res),
		.res_cnt(res_cnt)
	);

	jts_result_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_data(res),
		.wr_cnt(res_cnt),
		.room(room),
		.rd_valid(result_valid),
		.rd_stall(result_stall),
		.rd_data(head)
	);

	assign result_kind  = head.kind;
	assign token_index  = head.index;
	assign token_kind   = head.tkind;
	assign start_offset = head.start;
	assign token_length = head.length;
	assign last_of_run  = head.last;

endmodule
